FILE: src/ble_pkg.sv
// Shared types, line code numbers and sample level helper for the
// baseband line encoder. No dependencies.
package ble_pkg;

	typedef logic signed [1:0] sym_t;

	localparam sym_t SYM_POS  = 2'sb01;
	localparam sym_t SYM_NEG  = 2'sb11;
	localparam sym_t SYM_ZERO = 2'sb00;

	localparam logic [2:0] LC_RZ         = 3'd0;
	localparam logic [2:0] LC_POLAR      = 3'd1;
	localparam logic [2:0] LC_BIPOLAR    = 3'd2;
	localparam logic [2:0] LC_AMI_HALF   = 3'd3;
	localparam logic [2:0] LC_CMI        = 3'd4;
	localparam logic [2:0] LC_MANCHESTER = 3'd5;
	localparam logic [2:0] LC_HDB3       = 3'd6;

	localparam logic [2:0] REG_LINE_CODE = 3'd0;
	localparam logic [2:0] REG_SPB       = 3'd1;
	localparam logic [2:0] REG_AMPLITUDE = 3'd2;
	localparam logic [2:0] REG_RZ_ZEROS  = 3'd3;
	localparam logic [2:0] REG_PRECODE   = 3'd4;

	localparam int AMP_W    = 15;
	localparam int SAMPLE_W = 16;
	localparam int SPB_W    = 6;
	localparam int CFG_W    = 15;
	localparam logic [1:0] HDB3_LAST_ZERO = 2'd3;

	function automatic sym_t pol_sym(input logic neg);
		pol_sym = neg ? SYM_NEG : SYM_POS;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] level(input sym_t s,
			input logic [AMP_W-1:0] amp);
		logic signed [SAMPLE_W-1:0] mag;
		mag = $signed({1'b0, amp});
		if (s == SYM_POS)
			level = mag;
		else if (s == SYM_NEG)
			level = -mag;
		else
			level = '0;
	endfunction

endpackage

FILE: src/baseband_line_encoder.sv
// Baseband line encoder top level: config registers, per-bit symbol
// decision, sample sequencer and output register. Uses ble_pkg.
//
// Each accepted data bit produces samples_per_bit samples (0 treated as 1,
// clamped to MAX_SAMPLES_PER_BIT), one per cycle from a sample counter while
// sample_ready does not stall the output. A new bit is accepted in the same
// cycle as the previous bit's last sample moves to the output register.
// HDB3 output lags the input by three bits. Config must be written only while
// the block is idle; the block itself does not enforce it. cfg_ready is always high.
module baseband_line_encoder
	import ble_pkg::*;
#(
	parameter int MAX_SAMPLES_PER_BIT = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       bit_valid,
	output logic                       bit_ready,
	input  logic                       data_bit,
	output logic                       sample_valid,
	input  logic                       sample_ready,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic                       last_of_bit
);

	localparam int NW = $clog2(MAX_SAMPLES_PER_BIT + 1);
	localparam int CW = (NW > SPB_W) ? NW : SPB_W;

	logic [2:0]       line_code_q;
	logic [SPB_W-1:0] spb_q;
	logic [AMP_W-1:0] amp_q;
	logic [SPB_W-1:0] rz_zeros_q;
	logic             precode_q;

	logic             pol_q;
	logic signed [1:0] dc_q;
	logic [1:0]       zrun_q;
	logic             prev_bit_q;
	sym_t             dly_q [3];

	logic             d_valid_s1;
	sym_t             a_sym_s1;
	sym_t             b_sym_s1;
	logic [NW-1:0]    split_s1;
	logic [NW-1:0]    n_s1;
	logic [NW-1:0]    k_q;

	logic             out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic             last_q;

	logic [CW-1:0]    spb_ext, tail_ext;
	logic [NW-1:0]    n_c, half_c, tail_c;
	logic             bit_c;
	logic             pol_c;
	logic signed [2:0] dc_sum;
	logic signed [1:0] dc_c;
	logic [1:0]       zrun_c;
	sym_t             sym_c, a_c, b_c, oldest_c;
	logic [NW-1:0]    split_c;
	logic             accept, advance, d_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_code_q <= LC_POLAR;
			spb_q       <= SPB_W'(8);
			amp_q       <= AMP_W'(1);
			rz_zeros_q  <= SPB_W'(4);
			precode_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LINE_CODE: line_code_q <= cfg_data[2:0];
				REG_SPB:       spb_q       <= cfg_data[SPB_W-1:0];
				REG_AMPLITUDE: amp_q       <= cfg_data[AMP_W-1:0];
				REG_RZ_ZEROS:  rz_zeros_q  <= cfg_data[SPB_W-1:0];
				REG_PRECODE:   precode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sample count and rz tail clamps
	always_comb begin
		spb_ext  = CW'(spb_q);
		tail_ext = CW'(rz_zeros_q);
		if (spb_ext == '0)
			n_c = NW'(1);
		else if (spb_ext > CW'(MAX_SAMPLES_PER_BIT))
			n_c = NW'(MAX_SAMPLES_PER_BIT);
		else
			n_c = NW'(spb_ext);
		half_c = n_c >> 1;
		tail_c = (tail_ext > CW'(n_c)) ? n_c : NW'(tail_ext);
	end

	// per-bit symbol decision and state update
	always_comb begin
		bit_c    = precode_q ? (data_bit ^ prev_bit_q) : data_bit;
		pol_c    = pol_q;
		dc_c     = dc_q;
		zrun_c   = zrun_q;
		sym_c    = SYM_ZERO;
		oldest_c = dly_q[0];
		dc_sum   = 3'(dc_q);
		a_c      = SYM_ZERO;
		b_c      = SYM_ZERO;
		split_c  = n_c;
		unique case (line_code_q)
			LC_RZ: begin
				a_c     = bit_c ? SYM_POS : SYM_ZERO;
				split_c = n_c - tail_c;
			end
			LC_POLAR: begin
				a_c = bit_c ? SYM_POS : SYM_NEG;
			end
			LC_BIPOLAR, LC_AMI_HALF: begin
				a_c = bit_c ? pol_sym(pol_q) : SYM_ZERO;
				if (bit_c)
					pol_c = !pol_q;
				if (line_code_q == LC_AMI_HALF)
					split_c = n_c - half_c;
			end
			LC_CMI: begin
				if (bit_c) begin
					a_c   = pol_sym(pol_q);
					pol_c = !pol_q;
				end else begin
					a_c     = SYM_NEG;
					b_c     = SYM_POS;
					split_c = half_c;
				end
			end
			LC_MANCHESTER: begin
				a_c     = bit_c ? SYM_NEG : SYM_POS;
				b_c     = bit_c ? SYM_POS : SYM_NEG;
				split_c = half_c;
			end
			LC_HDB3: begin
				if (bit_c) begin
					pol_c  = !pol_q;
					sym_c  = pol_sym(pol_c);
					dc_sum = 3'(dc_q) + 3'(sym_c);
					zrun_c = '0;
				end else if (zrun_q == HDB3_LAST_ZERO) begin
					if (dc_q != '0) begin
						pol_c    = !pol_q;
						sym_c    = pol_sym(pol_c);
						oldest_c = sym_c;
						dc_sum   = 3'(dc_q) + (3'(sym_c) <<< 1);
					end else begin
						sym_c  = pol_sym(pol_q);
						dc_sum = 3'(dc_q) + 3'(sym_c);
					end
					zrun_c = '0;
				end else begin
					zrun_c = zrun_q + 2'd1;
				end
				if (dc_sum > 3'sd1)
					dc_c = 2'sd1;
				else if (dc_sum < -3'sd1)
					dc_c = -2'sd1;
				else
					dc_c = dc_sum[1:0];
				a_c = oldest_c;
			end
			default: ;
		endcase
		if (line_code_q != LC_RZ && line_code_q != LC_AMI_HALF &&
				line_code_q != LC_MANCHESTER &&
				!(line_code_q == LC_CMI && !bit_c))
			b_c = a_c;
	end

	assign d_last    = (k_q == n_s1 - NW'(1));
	assign advance   = d_valid_s1 && (!out_valid_q || sample_ready);
	assign bit_ready = !d_valid_s1 || (advance && d_last);
	assign accept    = bit_valid && bit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q      <= 1'b0;
			dc_q       <= '0;
			zrun_q     <= '0;
			prev_bit_q <= 1'b0;
			dly_q[0]   <= SYM_ZERO;
			dly_q[1]   <= SYM_ZERO;
			dly_q[2]   <= SYM_ZERO;
		end else if (accept) begin
			pol_q <= pol_c;
			if (precode_q)
				prev_bit_q <= data_bit;
			if (line_code_q == LC_HDB3) begin
				dc_q     <= dc_c;
				zrun_q   <= zrun_c;
				dly_q[0] <= dly_q[1];
				dly_q[1] <= dly_q[2];
				dly_q[2] <= sym_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_valid_s1 <= 1'b0;
			k_q        <= '0;
		end else begin
			if (accept) begin
				d_valid_s1 <= 1'b1;
				k_q        <= '0;
			end else if (advance) begin
				if (d_last)
					d_valid_s1 <= 1'b0;
				k_q <= k_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_sym_s1 <= a_c;
			b_sym_s1 <= b_c;
			split_s1 <= split_c;
			n_s1     <= n_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (sample_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q <= level((k_q < split_s1) ? a_sym_s1 : b_sym_s1, amp_q);
			last_q   <= d_last;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample       = sample_q;
	assign last_of_bit  = last_q;

endmodule
